>>> design/csvt_pkg.sv
// ----------------------------------------------------------------------------
// csvt_pkg
// Shared types and character constants for the CSV row tokenizer.
// ----------------------------------------------------------------------------
package csvt_pkg;

  localparam logic [7:0] SEP_RESET = 8'd44;

  localparam logic [7:0] CH_QUOTE  = 8'd34;
  localparam logic [7:0] CH_BSLASH = 8'd92;
  localparam logic [7:0] CH_HASH   = 8'd35;
  localparam logic [7:0] CH_LF     = 8'd10;
  localparam logic [7:0] CH_CR     = 8'd13;
  localparam logic [7:0] CH_TAB    = 8'd9;
  localparam logic [7:0] CH_VT     = 8'd11;
  localparam logic [7:0] CH_SPACE  = 8'd32;
  localparam logic [7:0] CH_N      = 8'd110;
  localparam logic [7:0] CH_R      = 8'd114;
  localparam logic [7:0] CH_T      = 8'd116;

  typedef enum logic [1:0] {
    FK_NONE     = 2'd0,
    FK_QUOTED   = 2'd1,
    FK_UNQUOTED = 2'd2,
    FK_UNUSED   = 2'd3
  } field_kind_t;

  typedef struct packed {
    field_kind_t field_kind;
    logic        inside_quotes;
    logic        escape_pending;
    logic        in_comment;
    logic        previous_was_quote;
    logic        row_has_data;
  } tok_state_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] out_byte;
    logic       ends_row;
  } tok_result_t;

endpackage

>>> design/csvt_step.sv
// ----------------------------------------------------------------------------
// csvt_step
// Combinational tokenizer step: one item and the current state in, the next
// state and at most one result out.
// ----------------------------------------------------------------------------
module csvt_step (
  input  csvt_pkg::tok_state_t  state,
  input  logic [7:0]            field_separator,
  input  logic                  kind,
  input  logic [7:0]            in_byte,
  output csvt_pkg::tok_state_t  state_next,
  output csvt_pkg::tok_result_t result
);
  import csvt_pkg::*;

  logic        ws_mode;
  logic        is_ws;
  logic        do_close;
  logic        do_emit;
  logic        pair_quote;
  logic [7:0]  emit_val;
  field_kind_t fk_eff;
  tok_state_t  st;

  assign ws_mode = (field_separator == 8'd0);
  assign is_ws   = (in_byte == CH_SPACE) || ((in_byte >= CH_TAB) && (in_byte <= CH_CR));

  always_comb begin
    st         = state;
    do_close   = 1'b0;
    do_emit    = 1'b0;
    pair_quote = 1'b0;
    emit_val   = in_byte;
    fk_eff     = state.field_kind;

    if (kind) begin
      do_close = 1'b1;
    end else if (state.in_comment) begin
      if (in_byte == CH_LF) begin
        do_close = 1'b1;
      end
    end else if (state.escape_pending) begin
      case (in_byte)
        CH_N:    emit_val = CH_LF;
        CH_R:    emit_val = CH_CR;
        CH_T:    emit_val = CH_TAB;
        default: emit_val = in_byte;
      endcase
      st.escape_pending = 1'b0;
      do_emit = 1'b1;
    end else if ((state.field_kind == FK_NONE) && ws_mode && (in_byte == CH_LF)) begin
      do_close = 1'b1;
    end else if ((state.field_kind == FK_NONE) && ws_mode && is_ws) begin
      // Leading whitespace between fields is skipped.
    end else if ((state.field_kind == FK_NONE) && ws_mode && (in_byte == CH_HASH)) begin
      st.in_comment = 1'b1;
    end else if ((state.field_kind == FK_NONE) && (in_byte == CH_QUOTE)) begin
      st.field_kind         = FK_QUOTED;
      st.inside_quotes      = 1'b1;
      st.previous_was_quote = 1'b0;
    end else begin
      if (state.field_kind == FK_NONE) begin
        st.field_kind = FK_UNQUOTED;
        fk_eff        = FK_UNQUOTED;
      end
      if (in_byte == CH_QUOTE) begin
        st.inside_quotes = !state.inside_quotes;
        if (fk_eff == FK_QUOTED) begin
          if (state.previous_was_quote) begin
            do_emit    = 1'b1;
            pair_quote = 1'b1;
          end else begin
            st.previous_was_quote = 1'b1;
          end
        end else begin
          do_emit = 1'b1;
        end
      end else if (in_byte == CH_BSLASH) begin
        st.escape_pending = 1'b1;
      end else if (!state.inside_quotes) begin
        if (in_byte == CH_CR) begin
          // An unquoted carriage return is dropped.
        end else if (in_byte == CH_LF) begin
          do_close = 1'b1;
        end else if ((ws_mode && is_ws) || (in_byte == field_separator)) begin
          emit_val      = 8'd0;
          st.field_kind = FK_NONE;
          do_emit       = 1'b1;
        end else begin
          do_emit = 1'b1;
        end
      end else if (!(ws_mode && is_ws)) begin
        do_emit = 1'b1;
      end
    end

    state_next      = st;
    result.valid    = 1'b0;
    result.out_byte = 8'd0;
    result.ends_row = 1'b0;

    if (do_close) begin
      result.valid = state.row_has_data;
      result.ends_row = 1'b1;
      state_next   = '0;
    end else if (do_emit) begin
      result.valid    = 1'b1;
      result.out_byte = emit_val;
      state_next.row_has_data = 1'b1;
      // A doubled quote inside a quoted field leaves no pending quote behind.
      state_next.previous_was_quote = (emit_val == CH_QUOTE) && !pair_quote;
    end
  end

endmodule

>>> design/csv_row_tokenizer_core.sv
// ----------------------------------------------------------------------------
// csv_row_tokenizer_core
// Streaming CSV row tokenizer, one source byte per clock unless the receiver stalls.
// ----------------------------------------------------------------------------
// Input beats arrive on s_*: s_tdata carries the source byte and s_tuser set
// marks end of input (the byte is then ignored). Output beats leave on m_*:
// a content byte in m_tdata (zero at a field boundary), or a row end with
// m_tlast set and m_tdata zero. Beats that produce nothing are absorbed.
// Each accepted beat is held in the input register, is tokenized on the way
// into the output register, and from there appears on m_*. One beat is taken
// every cycle unless the receiver stalls; the only loop is the flag bits of
// tokenizer state, which update as each beat advances.
// When the receiver stalls, the output register holds its beat and the input
// register holds one more; s_tready drops only when both are occupied.
// The user loads the separator through cfg_wr_en/cfg_wr_data only while idle;
// the block does not enforce it. Zero selects whitespace separation with hash
// comments. Reset (rst, synchronous) empties both registers, clears the row
// state and restores the separator to a comma.
// ----------------------------------------------------------------------------
module csv_row_tokenizer_core (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] in_byte
  input  logic       s_tuser,   // [0] kind
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] out_byte
  output logic       m_tlast    // ends_row
);
  import csvt_pkg::*;

  logic        [7:0] field_separator;
  logic              in_valid;
  logic        [7:0] in_byte;
  logic              in_kind;
  logic              advance;
  tok_state_t        state;
  tok_state_t        state_next;
  tok_result_t       result;

  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  csvt_step u_step (
    .state           (state),
    .field_separator (field_separator),
    .kind            (in_kind),
    .in_byte         (in_byte),
    .state_next      (state_next),
    .result          (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      field_separator <= SEP_RESET;
      in_valid        <= 1'b0;
      m_tvalid        <= 1'b0;
      state           <= '0;
    end else begin
      if (cfg_wr_en) begin
        field_separator <= cfg_wr_data;
      end
      if (s_tvalid && s_tready) begin
        in_valid <= 1'b1;
      end else if (advance) begin
        in_valid <= 1'b0;
      end
      if (advance) begin
        state    <= state_next;
        m_tvalid <= result.valid;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
      in_kind <= s_tuser;
    end
    if (advance && result.valid) begin
      m_tdata <= result.out_byte;
      m_tlast <= result.ends_row;
    end
  end

  // An empty input register always takes a beat.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !in_valid |-> s_tready)
    else $error("input register empty but s_tready low");

  // A row end never carries a byte.
  a_row_end_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tlast) |-> (m_tdata == 8'd0))
    else $error("row end beat with nonzero data");

  // A row end leaves the row state fully cleared.
  a_row_end_clears: assert property (@(posedge clk) disable iff (rst)
    (advance && result.valid && result.ends_row) |=> (state == '0))
    else $error("row state not cleared after row end");

  // Any byte beat marks the row as holding data.
  a_byte_sets_data: assert property (@(posedge clk) disable iff (rst)
    (advance && result.valid && !result.ends_row) |=> state.row_has_data)
    else $error("row_has_data not set after byte beat");

endmodule
